FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is asserted
`define BSFN_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define BSFN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/bsfn_pkg.sv
// shared widths, opcodes and defaults of the membership bitmap
`default_nettype none

package bsfn_pkg;

    localparam int OP_W             = 2;
    localparam int ID_W             = 10;
    localparam int POS_W            = 11;
    localparam int WORD_BITS        = 64;
    localparam int WORD_SH          = 6;
    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int S_TDATA_W        = 24;
    localparam int M_TDATA_W        = 32;

    localparam logic [OP_W-1:0] OP_CONTAINS = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD      = 2'd1;
    localparam logic [OP_W-1:0] OP_NEXT     = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/bitmap_set_with_find_next.sv
// membership bitmap with contains, add and find-next-set-bit over a word memory
//
// s_* channel: one request beat; s_tuser is the operation (contains, add, find next),
//   s_tdata carries element_id and start_position
// m_* channel: one result beat per request; m_tuser is the success flag,
//   m_tdata carries found_id, next_cursor and member_count
// cfg_* channel: writes element_count while idle and no request beat is offered;
//   the write clears the bitmap and member count through per-word valid bits
// steps from accept to m_tvalid, with a free output register
//   contains / add: one memory read (EVAL), then compare and write back (ACC)
//   answered without a read (id or start at or past the count, unused opcode): EVAL only
//   find next: read of the start word (EVAL), then one SCAN step per word up to word k,
//     where the search ends, plus a TZ step when word k holds the hit; k is at most 15
//     with 1024 elements; the single memory read port gives one 64-bit word per cycle
// one request in flight at a time: a new beat is taken the cycle after the result
//   is loaded into the output register, even while stalled; no request is taken
//   while the previous one is still in progress
// reset clears the element count, the member count, all word valid bits and m_tvalid
// a stalled receiver holds the result register; a finished request then waits in
//   its last step, keeping its read data, until the register frees up
`default_nettype none

module bitmap_set_with_find_next #(
    parameter int MAX_ELEMENTS = bsfn_pkg::MAX_ELEMENTS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // request channel
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [bsfn_pkg::S_TDATA_W-1:0] s_tdata,  // element_id, start_position, pad
    input  wire logic [bsfn_pkg::OP_W-1:0]      s_tuser,  // operation
    // result channel
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [bsfn_pkg::M_TDATA_W-1:0]      m_tdata,  // found_id, next_cursor, member_count
    output logic                                m_tuser,  // success
    // element count register
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bsfn_pkg::POS_W-1:0]     cfg_data
);

    localparam int ID_W      = bsfn_pkg::ID_W;
    localparam int POS_W     = bsfn_pkg::POS_W;
    localparam int WB        = bsfn_pkg::WORD_BITS;
    localparam int SH        = bsfn_pkg::WORD_SH;
    // ids beyond what an 11-bit count reaches are never touched
    localparam int CAP_MAX   = (1 << POS_W) - 1;
    localparam int CAP       = (MAX_ELEMENTS > CAP_MAX) ? CAP_MAX : MAX_ELEMENTS;
    localparam int MEM_WORDS = (CAP + WB - 1) / WB;
    localparam int WA        = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int WI_W      = POS_W - SH + 1;
    localparam int PW        = WI_W + SH;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EVAL = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_TZ   = 3'd4;

    // trailing zero count: first nonzero byte, then first set bit inside it
    function automatic logic [SH-1:0] tz64(input logic [WB-1:0] w);
        logic [7:0] nz;
        logic [7:0] b;
        logic [2:0] bsel;
        logic [2:0] bpos;
        int         i;
        for (i = 0; i < 8; i++)
        begin
            nz[i] = |w[8*i +: 8];
        end
        bsel = 3'd0;
        for (i = 7; i >= 0; i--)
        begin
            if (nz[i])
            begin
                bsel = 3'(i);
            end
        end
        b    = w[{bsel, 3'b000} +: 8];
        bpos = 3'd0;
        for (i = 7; i >= 0; i--)
        begin
            if (b[i])
            begin
                bpos = 3'(i);
            end
        end
        return {bsel, bpos};
    endfunction

    logic [2:0]                 state_reg, state_next;
    logic [bsfn_pkg::OP_W-1:0]  op_reg;
    logic [ID_W-1:0]            id_reg;
    logic [POS_W-1:0]           start_reg;
    logic [POS_W-1:0]           count_reg;
    logic [POS_W-1:0]           elem_count_reg;
    logic [POS_W-1:0]           members_reg, members_next;
    logic [MEM_WORDS-1:0]       valid_reg;
    logic [WI_W-1:0]            widx_reg, widx_next;
    logic                       first_reg, first_next;
    logic [WB-1:0]              hit_reg;

    // word memory and its registered read port
    logic [WB-1:0]              mem [MEM_WORDS];
    logic [WB-1:0]              rd_data_reg;
    logic                       rd_ok_reg;
    logic                       rd_en;
    logic [WA-1:0]              rd_addr;
    logic                       wr_en;
    logic [WA-1:0]              wr_addr;
    logic [WB-1:0]              wr_data;

    logic                       m_tvalid_reg;
    logic                       res_success_reg;
    logic [ID_W-1:0]            res_found_reg;
    logic [POS_W-1:0]           res_cursor_reg;
    logic [POS_W-1:0]           res_members_reg;

    logic                       in_fire;
    logic                       cfg_fire;
    logic                       out_free;
    logic                       emit;
    logic                       emit_success;
    logic [ID_W-1:0]            emit_found;
    logic [POS_W-1:0]           emit_cursor;
    logic [POS_W-1:0]           count_eff;
    logic [WI_W-1:0]            words_used;
    logic [WB-1:0]              first_mask;
    logic [WB-1:0]              scan_word;
    logic [WB-1:0]              acc_word;
    logic                       acc_bit;
    logic [PW-1:0]              hit_pos;
    logic [WI_W-1:0]            widx_inc;

    assign s_tready  = (state_reg == ST_IDLE);
    // an offered request beat goes first, so a count write never meets an accept
    assign cfg_ready = (state_reg == ST_IDLE) && !s_tvalid;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = res_success_reg;
    assign m_tdata  = {res_members_reg, res_cursor_reg, res_found_reg};

    // counts above capacity saturate
    assign count_eff  = (elem_count_reg > POS_W'(CAP)) ? POS_W'(CAP) : elem_count_reg;
    assign words_used = WI_W'(({1'b0, count_reg} + PW'(WB - 1)) >> SH);
    assign first_mask = {WB{1'b1}} << start_reg[SH-1:0];
    assign acc_word   = rd_ok_reg ? rd_data_reg : '0;
    assign acc_bit    = acc_word[id_reg[SH-1:0]];
    assign scan_word  = acc_word & (first_reg ? first_mask : {WB{1'b1}});
    assign hit_pos    = {widx_reg, tz64(hit_reg)};
    assign widx_inc   = widx_reg + 1'b1;

    always_comb
    begin
        state_next   = state_reg;
        members_next = members_reg;
        widx_next    = widx_reg;
        first_next   = first_reg;
        rd_en        = 1'b0;
        rd_addr      = WA'(id_reg >> SH);
        wr_en        = 1'b0;
        wr_addr      = WA'(id_reg >> SH);
        wr_data      = acc_word | (WB'(1) << id_reg[SH-1:0]);
        emit         = 1'b0;
        emit_success = 1'b0;
        emit_found   = '0;
        emit_cursor  = start_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if ((op_reg == bsfn_pkg::OP_CONTAINS || op_reg == bsfn_pkg::OP_ADD)
                    && ({1'b0, id_reg} < count_reg))
                begin
                    rd_en      = 1'b1;
                    state_next = ST_ACC;
                end
                else if (op_reg == bsfn_pkg::OP_NEXT && start_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = WA'(start_reg >> SH);
                    widx_next  = WI_W'(start_reg >> SH);
                    first_next = 1'b1;
                    state_next = ST_SCAN;
                end
                else if (out_free)
                begin
                    // out of range, start at or past count or unused opcode
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_ACC:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    if (op_reg == bsfn_pkg::OP_CONTAINS)
                    begin
                        emit_success = acc_bit;
                    end
                    else if (!acc_bit)
                    begin
                        wr_en        = 1'b1;
                        emit_success = 1'b1;
                        members_next = members_reg + 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_word != '0)
                begin
                    state_next = ST_TZ;
                end
                else if (widx_inc >= words_used)
                begin
                    if (out_free)
                    begin
                        emit        = 1'b1;
                        emit_cursor = count_reg;
                        state_next  = ST_IDLE;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = WA'(widx_inc);
                    widx_next  = widx_inc;
                    first_next = 1'b0;
                end
            end
            ST_TZ:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    state_next  = ST_IDLE;
                    emit_cursor = count_reg;
                    if (hit_pos < PW'(count_reg))
                    begin
                        emit_success = 1'b1;
                        emit_found   = hit_pos[ID_W-1:0];
                        emit_cursor  = POS_W'(hit_pos + 1'b1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            elem_count_reg <= '0;
            members_reg    <= '0;
            valid_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
            rd_ok_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_fire)
            begin
                elem_count_reg <= cfg_data;
                members_reg    <= '0;
                valid_reg      <= '0;
            end
            else
            begin
                members_reg <= members_next;
                if (wr_en)
                begin
                    valid_reg[wr_addr] <= 1'b1;
                end
            end
            if (rd_en)
            begin
                rd_ok_reg <= valid_reg[rd_addr];
            end
            if (emit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // request and scan payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg    <= s_tuser;
            id_reg    <= s_tdata[ID_W-1:0];
            start_reg <= s_tdata[ID_W +: POS_W];
            count_reg <= count_eff;
        end
        widx_reg  <= widx_next;
        first_reg <= first_next;
        if (state_reg == ST_SCAN)
        begin
            hit_reg <= scan_word;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_success_reg <= emit_success;
            res_found_reg   <= emit_found;
            res_cursor_reg  <= emit_cursor;
            res_members_reg <= members_next;
        end
    end

    // word memory, one read and one write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bsfn_checker.sv
// port-level checks of the membership bitmap, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module bsfn_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           cfg_valid,
    input wire logic                           cfg_ready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [bsfn_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                           m_tuser
);

    // stalled result beat holds
    `BSFN_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

    // no result beat once reset has been seen at an edge
    `BSFN_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !m_tvalid, "result valid after reset")

    // one request in flight: no second beat right after an accept
    `BSFN_ASSERT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready |=> !s_tready, "request taken while busy")

    // register writes only taken while the request channel is ready
    `BSFN_ASSERT(a_cfg_idle, clk, rst_n, cfg_valid && cfg_ready |-> s_tready, "count written while busy")

endmodule

bind bitmap_set_with_find_next bsfn_checker u_bsfn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);

`default_nettype wire

FILE: sim/tb.sv
// self-checking testbench of the membership bitmap with contains, add and find next
module tb;
    import bsfn_pkg::*;

    // operation code the block leaves unused
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    // settling wait after the longest find next, with margin
    localparam int SCAN_LATENCY = 24;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PAD_W        = S_TDATA_W - ID_W - POS_W;
    localparam int WORDS_TOTAL  = MAX_ELEMENTS_DEF / WORD_BITS;
    localparam int PHASE_ITEMS  = 67;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [ID_W-1:0]  id;
        logic [POS_W-1:0] start;
    } request_t;

    // follow_cursor: take the start position from the cursor of the previous answer
    typedef struct {
        request_t req;
        bit       follow_cursor;
    } queued_request_t;

    typedef struct packed {
        logic             success;
        logic [ID_W-1:0]  found_id;
        logic [POS_W-1:0] cursor;
        logic [POS_W-1:0] members;
    } response_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [OP_W-1:0]      s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [POS_W-1:0]     cfg_data  = '0;

    // mirror of the block state, kept by the predictor
    logic [WORD_BITS-1:0] mirror_words [WORDS_TOTAL];
    logic [POS_W-1:0]     mirror_members;
    logic [POS_W-1:0]     mirror_count;

    queued_request_t request_q[$];     // requests waiting for the driver
    response_t       response_q[$];    // answers predicted for accepted requests

    // driver state
    request_t         cur_req = '0;
    queued_request_t  next_item;
    bit               loaded = 1'b0;
    int               hold_cycles = 0;
    logic [POS_W-1:0] last_cursor = '0;

    // monitor state
    response_t        exp_rsp;
    int               stall_cycles = 0;

    // idle lengths of the current phase, 0 gives back-to-back beats
    int gap_max   = 16;
    int stall_max = 16;

    int cycle_cnt    = 0;
    int error_cnt    = 0;
    int accepted_cnt = 0;
    int checked_cnt  = 0;
    int success_cnt  = 0;
    int cfg_writes   = 0;

    bitmap_set_with_find_next #(
        .MAX_ELEMENTS(MAX_ELEMENTS_DEF)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // answer of the bitmap to one request, updating the mirror for an add
    function automatic response_t predict_response(request_t rq);
        int        eff;
        int        p;
        response_t rsp;
        // counts above capacity saturate
        eff = (int'(mirror_count) > MAX_ELEMENTS_DEF) ? MAX_ELEMENTS_DEF : int'(mirror_count);
        rsp.success  = 1'b0;
        rsp.found_id = '0;
        rsp.cursor   = rq.start;
        case (rq.op)
            OP_CONTAINS:
            begin
                if (int'(rq.id) < eff)
                    rsp.success = mirror_words[rq.id / WORD_BITS][rq.id % WORD_BITS];
            end
            OP_ADD:
            begin
                // out of range or already present: nothing changes
                if (int'(rq.id) < eff && !mirror_words[rq.id / WORD_BITS][rq.id % WORD_BITS])
                begin
                    mirror_words[rq.id / WORD_BITS][rq.id % WORD_BITS] = 1'b1;
                    mirror_members = mirror_members + 1'b1;
                    rsp.success    = 1'b1;
                end
            end
            OP_NEXT:
            begin
                // start at or past the count leaves the cursor alone,
                // otherwise a miss moves it to the count
                if (int'(rq.start) < eff)
                begin
                    rsp.cursor = POS_W'(eff);
                    for (p = int'(rq.start); p < eff; p++)
                    begin
                        if (mirror_words[p / WORD_BITS][p % WORD_BITS])
                        begin
                            rsp.success  = 1'b1;
                            rsp.found_id = ID_W'(p);
                            rsp.cursor   = POS_W'(p + 1);
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        rsp.members = mirror_members;
        return rsp;
    endfunction

    task automatic compare_field(string name, logic [POS_W-1:0] expv, logic [POS_W-1:0] actv);
        if (expv !== actv)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, expv, actv);
            error_cnt++;
        end
    endtask

    // driver: one request beat at a time, each after a random hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid    <= 1'b0;
            s_tdata     <= '0;
            s_tuser     <= '0;
            loaded      = 1'b0;
            hold_cycles = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                // the beat is taken at this edge: predict its answer now
                response_q.push_back(predict_response(cur_req));
                last_cursor = response_q[$].cursor;
                accepted_cnt++;
                loaded = 1'b0;
            end
            if (!loaded && request_q.size() != 0)
            begin
                next_item = request_q.pop_front();
                cur_req   = next_item.req;
                if (next_item.follow_cursor)
                    cur_req.start = last_cursor;
                loaded      = 1'b1;
                hold_cycles = $urandom_range(gap_max);
            end
            // valid held high from one beat to the next when no gap is drawn
            if (loaded && hold_cycles == 0)
                s_tvalid <= 1'b1;
            else
            begin
                s_tvalid <= 1'b0;
                if (hold_cycles != 0)
                    hold_cycles--;
            end
            s_tdata <= {{PAD_W{1'b0}}, cur_req.start, cur_req.id};
            s_tuser <= cur_req.op;
        end
    end

    // monitor: checks each result beat against the oldest prediction,
    // then backs off ready for a random number of cycles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready     <= 1'b0;
            stall_cycles = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (response_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing outstanding, expected none actual %h/%b",
                             $time, m_tdata, m_tuser);
                    error_cnt++;
                end
                else
                begin
                    exp_rsp = response_q.pop_front();
                    compare_field("success", POS_W'(exp_rsp.success), POS_W'(m_tuser));
                    compare_field("found_id", POS_W'(exp_rsp.found_id),
                                  POS_W'(m_tdata[ID_W-1:0]));
                    compare_field("next_cursor", exp_rsp.cursor, m_tdata[ID_W+POS_W-1:ID_W]);
                    compare_field("member_count", exp_rsp.members,
                                  m_tdata[ID_W+2*POS_W-1:ID_W+POS_W]);
                    if (exp_rsp.success)
                        success_cnt++;
                end
                checked_cnt++;
                stall_cycles = $urandom_range(stall_max);
            end
            else if (stall_cycles != 0)
                stall_cycles--;
            m_tready <= (stall_cycles == 0);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d answers outstanding",
                     cycle_cnt, response_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic push_item(logic [OP_W-1:0] op, int id, int start, bit follow);
        queued_request_t item;
        item.req.op        = op;
        item.req.id        = ID_W'(id);
        item.req.start     = POS_W'(start);
        item.follow_cursor = follow;
        request_q.push_back(item);
    endtask

    // wait until every request has been answered, then let the block settle
    task automatic wait_idle();
        do
            @(posedge clk);
        while (request_q.size() != 0 || loaded || response_q.size() != 0);
        repeat (SCAN_LATENCY) @(posedge clk);
    endtask

    // element count write; it also empties the bitmap
    task automatic write_element_count(int value);
        int w;
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= POS_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        mirror_count   = POS_W'(value);
        mirror_members = '0;
        for (w = 0; w < WORDS_TOTAL; w++)
            mirror_words[w] = '0;
        cfg_writes++;
    endtask

    // random requests, mostly ids and starts inside the count, with walks
    // of find next requests that resume from the previous cursor
    task automatic queue_random_phase(int n_items);
        int eff;
        int sel;
        int id;
        int start;
        int k;
        eff = (int'(mirror_count) > MAX_ELEMENTS_DEF) ? MAX_ELEMENTS_DEF : int'(mirror_count);
        for (k = 0; k < n_items; k++)
        begin
            sel   = $urandom_range(99);
            id    = (eff > 0 && $urandom_range(99) < 85) ? $urandom_range(eff - 1)
                                                         : $urandom_range(MAX_ELEMENTS_DEF - 1);
            start = (eff > 0 && $urandom_range(99) < 85) ? $urandom_range(eff - 1)
                                                         : $urandom_range(2047);
            if (sel < 40)
                push_item(OP_ADD, id, start, 1'b0);
            else if (sel < 62)
                push_item(OP_CONTAINS, id, start, 1'b0);
            else if (sel < 80)
                push_item(OP_NEXT, id, start, 1'b0);
            else if (sel < 95)
                push_item(OP_NEXT, id, start, 1'b1);
            else
                push_item(OP_UNUSED, id, start, 1'b0);
        end
    endtask

    initial
    begin
        int ph;
        int counts [9];
        counts = '{1024, 65, 2047, 64, 1, 0, 1025, 0, 1024};
        counts[7] = $urandom_range(MAX_ELEMENTS_DEF);

        // mirror starts in the reset state
        mirror_count   = '0;
        mirror_members = '0;
        for (ph = 0; ph < WORDS_TOTAL; ph++)
            mirror_words[ph] = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // count of zero after reset: everything out of range
        push_item(OP_CONTAINS, 0, 0, 1'b0);
        push_item(OP_ADD, 1023, 0, 1'b0);
        push_item(OP_NEXT, 0, 0, 1'b0);
        push_item(OP_UNUSED, 1023, 1024, 1'b0);
        wait_idle();

        // full capacity: empty scan, duplicates, word boundaries, the top id
        write_element_count(MAX_ELEMENTS_DEF);
        push_item(OP_NEXT, 0, 0, 1'b0);
        push_item(OP_ADD, 0, 0, 1'b0);
        push_item(OP_ADD, 0, 0, 1'b0);
        push_item(OP_ADD, 1023, 0, 1'b0);
        push_item(OP_ADD, 63, 0, 1'b0);
        push_item(OP_ADD, 64, 0, 1'b0);
        push_item(OP_CONTAINS, 0, 0, 1'b0);
        push_item(OP_CONTAINS, 1023, 0, 1'b0);
        push_item(OP_CONTAINS, 5, 0, 1'b0);
        push_item(OP_NEXT, 0, 0, 1'b0);
        push_item(OP_NEXT, 0, 0, 1'b1);
        push_item(OP_NEXT, 0, 0, 1'b1);
        push_item(OP_NEXT, 0, 0, 1'b1);
        push_item(OP_NEXT, 0, 0, 1'b1);
        push_item(OP_NEXT, 0, 0, 1'b1);
        push_item(OP_NEXT, 0, 1024, 1'b0);
        push_item(OP_NEXT, 0, 2047, 1'b0);
        push_item(OP_UNUSED, 512, 77, 1'b0);
        wait_idle();

        // random phases over several counts; every third one runs without gaps
        for (ph = 0; ph < 9; ph++)
        begin
            write_element_count(counts[ph]);
            gap_max   = (ph % 3 == 2) ? 0 : 16;
            stall_max = (ph % 3 == 2) ? 0 : 16;
            queue_random_phase(PHASE_ITEMS);
            wait_idle();
        end

        $display("ran %0d requests across %0d element count writes, checked %0d results",
                 accepted_cnt, cfg_writes, checked_cnt);
        $display("%0d answers reported success, %0d mismatches", success_cnt, error_cnt);
        if (error_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
